// ----- hw/rtl/mips_integer_instruction_executor_top_assert.svh -----
// Assertion macros for the integer executor
`ifndef MIPS_INTEGER_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH
`define MIPS_INTEGER_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH
// Implication checked on every clock, off during reset
`define MIE_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Implication checked in the next cycle
`define MIE_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ----- hw/rtl/mie_pkg.sv -----
// ----------------------------------------------------------------------------
// mie_pkg
// Types and constants shared by the integer executor modules.
// ----------------------------------------------------------------------------
`default_nettype none
package mie_pkg;
  localparam logic [31:0] ENTRY_RESET = 32'h1000_0000;

  localparam logic [2:0] KIND_RETIRED = 3'd0;
  localparam logic [2:0] KIND_READ    = 3'd1;
  localparam logic [2:0] KIND_WRITE   = 3'd2;
  localparam logic [2:0] KIND_OVF     = 3'd3;
  localparam logic [2:0] KIND_RSVD    = 3'd4;
  localparam logic [2:0] KIND_HALT    = 3'd5;

  localparam logic [2:0] LK_LB  = 3'd0;
  localparam logic [2:0] LK_LBU = 3'd1;
  localparam logic [2:0] LK_LH  = 3'd2;
  localparam logic [2:0] LK_LHU = 3'd3;
  localparam logic [2:0] LK_LW  = 3'd4;
  localparam logic [2:0] LK_LWL = 3'd5;
  localparam logic [2:0] LK_LWR = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_OUT
  } state_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic        sgn;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- hw/rtl/mie_div.sv -----
// ----------------------------------------------------------------------------
// mie_div
// Radix-2 restoring divider, one quotient bit per cycle, sign fixup at end.
// ----------------------------------------------------------------------------
`default_nettype none
module mie_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mie_pkg::div_req_t req,
  output mie_pkg::div_rsp_t     rsp
);
  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [31:0] rem, quo, dvs;
  logic        neg_q, neg_r;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};

  // iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_q <= req.sgn & (req.a[31] ^ req.b[31]);
      neg_r <= req.sgn & req.a[31];
      quo <= (req.sgn & req.a[31]) ? 32'd0 - req.a : req.a;
      dvs <= (req.sgn & req.b[31]) ? 32'd0 - req.b : req.b;
      rem <= '0;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo = neg_q ? 32'd0 - quo : quo;
  assign rsp.rem = neg_r ? 32'd0 - rem : rem;
endmodule
`default_nettype wire

// ----- hw/rtl/mips_integer_instruction_executor_top.sv -----
// ----------------------------------------------------------------------------
// mips_integer_instruction_executor_top
// Multi-cycle MIPS-I integer core with delay slot, registers in a memory.
// ----------------------------------------------------------------------------
// Channel  Dir  Content
// s_axis   in   tuser=mode, tdata=instruction[31:0], load_data[63:32]
// m_axis   out  tdata=kind,address,write_data,byte_enable,next_pc,exit_value
// apb      in   entry_address at byte address 0
// An item passes accept, register file read (registered memory read, rs
// and rt from two read ports), execute and, if it produces one, result register.
// div/divu with a nonzero divisor also pass through the bit-serial divider. A waiting
// result blocks the next transfer until taken. Reset is synchronous; the register
// file is swept to zero after reset, with no item accepted meanwhile.
`default_nettype none
`include "mips_integer_instruction_executor_top_assert.svh"
module mips_integer_instruction_executor_top #(
  parameter logic [31:0] EntryReset = mie_pkg::ENTRY_RESET
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,   // instruction, load_data
  input  wire logic         s_axis_tuser,   // mode
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [111:0]      m_axis_tdata,   // kind, address, write_data, byte_enable,
                                            // next_pc, exit_value, zero pad
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  mie_pkg::state_t st, st_next;

  logic [31:0] rf [32];
  logic [31:0] ra, rb;
  logic        clr_busy;
  logic [4:0]  clr_idx;

  logic [31:0] entry, pc, hi, lo, dtgt;
  logic        dpend, lpend, stopped;
  logic [2:0]  lkind;
  logic [4:0]  ldest;
  logic [1:0]  loff;

  logic        mode;
  logic [31:0] ins, ldata;
  logic [4:0]  a_idx, b_idx;

  logic        we;
  logic [4:0]  wa;
  logic [31:0] wd;

  logic [2:0]  o_kind;
  logic [31:0] o_addr, o_wd, o_pc;
  logic [3:0]  o_be;
  logic [7:0]  o_exit;

  mie_pkg::div_req_t dreq;
  mie_pkg::div_rsp_t drsp;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr == 2'd0);
  assign prdata = entry;

  assign s_axis_tready = (st == mie_pkg::ST_IDLE) & ~clr_busy;
  logic in_xfer;
  assign in_xfer = s_axis_tvalid & s_axis_tready;

  // next state
  logic exec_go, is_div;
  always_comb begin
    st_next = st;
    case (st)
      mie_pkg::ST_IDLE: if (in_xfer) st_next = mie_pkg::ST_READ;
      mie_pkg::ST_READ: st_next = mie_pkg::ST_EXEC;
      mie_pkg::ST_EXEC: begin
        if (dreq.start) st_next = mie_pkg::ST_DIV;
        else if (exec_go) st_next = mie_pkg::ST_OUT;
        else st_next = mie_pkg::ST_IDLE;
      end
      mie_pkg::ST_DIV: if (drsp.done) st_next = mie_pkg::ST_OUT;
      mie_pkg::ST_OUT: if (m_axis_tready) st_next = mie_pkg::ST_IDLE;
      default: st_next = mie_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= mie_pkg::ST_IDLE;
    else st <= st_next;
  end

  // outputs
  always_comb begin
    m_axis_tvalid = (st == mie_pkg::ST_OUT);
  end
  assign m_axis_tdata = {1'd0, o_exit, o_pc, o_be, o_wd, o_addr, o_kind};

  // capture item
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode <= s_axis_tuser;
      ins <= s_axis_tdata[31:0];
      ldata <= s_axis_tdata[63:32];
    end
  end
  // read addresses: load completion reads old dest as port a, halt reads $2
  assign a_idx = mode ? ldest : ins[25:21];
  assign b_idx = (mode || stopped || pc == 32'd0) ? 5'd2 : ins[20:16];

  // register file memory with clearing sweep
  always_ff @(posedge clk) begin
    if (clr_busy) rf[clr_idx] <= '0;
    else if (we) rf[wa] <= wd;
    ra <= rf[a_idx];
    rb <= rf[b_idx];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 5'd1;
      if (clr_idx == 5'd31) clr_busy <= 1'b0;
    end
  end

  // decode and execute
  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sa, sh;
  logic [31:0] a, b, simm, imm, ea, bt, cur, link, ex_v, sum, dif, pc4;
  logic [31:0] ld_v, ld_sh;
  logic [63:0] prod;
  logic signed [65:0] prod_x;
  logic        msgn;
  logic        nb, wen, ovf, rsvd, ismul, wr_hi, wr_lo, is_ld, halt_now;
  logic [4:0]  wreg;
  logic [31:0] ntgt, hi_v, lo_v;
  logic [2:0]  kind_c;
  logic [2:0]  lk_c;
  logic [31:0] st_wd;
  logic [3:0]  st_be;
  logic        st_op;
  logic [1:0]  off;

  assign op = ins[31:26];
  assign fn = ins[5:0];
  assign rt = ins[20:16];
  assign rd = ins[15:11];
  assign sa = ins[10:6];
  assign a = (ins[25:21] == 5'd0) ? 32'd0 : ra;
  assign b = (rt == 5'd0) ? 32'd0 : rb;
  assign imm = {16'd0, ins[15:0]};
  assign simm = {{16{ins[15]}}, ins[15:0]};
  assign cur = pc;
  assign pc4 = cur + 32'd4;
  assign ea = a + simm;
  assign off = ea[1:0];
  assign bt = pc4 + {simm[29:0], 2'b00};
  assign link = cur + 32'd8;
  assign sum = a + b;
  assign dif = a - b;
  assign sh = fn[2] ? a[4:0] : sa;
  // one 33x33 signed multiplier serves mult and multu
  assign msgn = (fn == 6'h18);
  assign prod_x = $signed({msgn & a[31], a}) * $signed({msgn & b[31], b});
  assign prod = prod_x[63:0];

  always_comb begin
    nb = 1'b0; ntgt = '0; wen = 1'b0; wreg = rd; ex_v = '0;
    ovf = 1'b0; rsvd = 1'b0; ismul = 1'b0; wr_hi = 1'b0; wr_lo = 1'b0;
    hi_v = a; lo_v = a; is_ld = 1'b0; lk_c = mie_pkg::LK_LW;
    st_op = 1'b0; st_wd = '0; st_be = '0; is_div = 1'b0;
    case (op)
      6'h00: begin
        wen = 1'b1;
        case (fn)
          6'h00, 6'h04: ex_v = b << sh;
          6'h02, 6'h06: ex_v = b >> sh;
          6'h03, 6'h07: ex_v = 32'($signed(b) >>> sh);
          6'h08: begin wen = 1'b0; nb = 1'b1; ntgt = a; end
          6'h09: begin nb = 1'b1; ntgt = a; ex_v = link; end
          6'h10: ex_v = hi;
          6'h11: begin wen = 1'b0; wr_hi = 1'b1; end
          6'h12: ex_v = lo;
          6'h13: begin wen = 1'b0; wr_lo = 1'b1; end
          6'h18, 6'h19: begin
            wen = 1'b0; ismul = 1'b1; wr_hi = 1'b1; wr_lo = 1'b1;
            hi_v = prod[63:32]; lo_v = prod[31:0];
          end
          6'h1A, 6'h1B: begin wen = 1'b0; is_div = (b != 32'd0); end
          6'h20: begin ex_v = sum; ovf = (a[31] == b[31]) && (sum[31] != a[31]); end
          6'h21: ex_v = sum;
          6'h22: begin ex_v = dif; ovf = (a[31] != b[31]) && (dif[31] != a[31]); end
          6'h23: ex_v = dif;
          6'h24: ex_v = a & b;
          6'h25: ex_v = a | b;
          6'h26: ex_v = a ^ b;
          6'h2A: ex_v = {31'd0, $signed(a) < $signed(b)};
          6'h2B: ex_v = {31'd0, a < b};
          default: begin wen = 1'b0; rsvd = 1'b1; end
        endcase
      end
      6'h01: begin
        wreg = 5'd31; ex_v = link; ntgt = bt;
        case (rt)
          5'h00: nb = a[31];
          5'h01: nb = ~a[31];
          5'h10: begin nb = a[31]; wen = 1'b1; end
          5'h11: begin nb = ~a[31]; wen = 1'b1; end
          default: rsvd = 1'b1;
        endcase
      end
      6'h02, 6'h03: begin
        nb = 1'b1; wreg = 5'd31; ex_v = link; wen = op[0];
        ntgt = {pc4[31:28], ins[25:0], 2'b00};
      end
      6'h04: begin nb = (a == b); ntgt = bt; end
      6'h05: begin nb = (a != b); ntgt = bt; end
      6'h06: begin nb = (a == 32'd0) | a[31]; ntgt = bt; end
      6'h07: begin nb = (a != 32'd0) & ~a[31]; ntgt = bt; end
      6'h08: begin
        wen = 1'b1; wreg = rt; ex_v = ea;
        ovf = (a[31] == simm[31]) && (ea[31] != a[31]);
      end
      6'h09: begin wen = 1'b1; wreg = rt; ex_v = ea; end
      6'h0A: begin wen = 1'b1; wreg = rt; ex_v = {31'd0, $signed(a) < $signed(simm)}; end
      6'h0B: begin wen = 1'b1; wreg = rt; ex_v = {31'd0, a < simm}; end
      6'h0C: begin wen = 1'b1; wreg = rt; ex_v = a & imm; end
      6'h0D: begin wen = 1'b1; wreg = rt; ex_v = a | imm; end
      6'h0E: begin wen = 1'b1; wreg = rt; ex_v = a ^ imm; end
      6'h0F: begin wen = 1'b1; wreg = rt; ex_v = {ins[15:0], 16'd0}; end
      6'h20: begin is_ld = 1'b1; lk_c = mie_pkg::LK_LB; end
      6'h21: begin is_ld = 1'b1; lk_c = mie_pkg::LK_LH; end
      6'h22: begin is_ld = 1'b1; lk_c = mie_pkg::LK_LWL; end
      6'h23: begin is_ld = 1'b1; lk_c = mie_pkg::LK_LW; end
      6'h24: begin is_ld = 1'b1; lk_c = mie_pkg::LK_LBU; end
      6'h25: begin is_ld = 1'b1; lk_c = mie_pkg::LK_LHU; end
      6'h26: begin is_ld = 1'b1; lk_c = mie_pkg::LK_LWR; end
      6'h28: begin
        st_op = 1'b1;
        st_wd = {24'd0, b[7:0]} << {~off, 3'b000};
        st_be = 4'b1000 >> off;
      end
      6'h29: begin
        st_op = 1'b1;
        st_wd = off[1] ? {16'd0, b[15:0]} : {b[15:0], 16'd0};
        st_be = off[1] ? 4'b0011 : 4'b1100;
      end
      6'h2B: begin st_op = 1'b1; st_wd = b; st_be = 4'hF; end
      default: rsvd = 1'b1;
    endcase
    if (ovf | rsvd) is_div = 1'b0;
  end

  assign kind_c = rsvd ? mie_pkg::KIND_RSVD : ovf ? mie_pkg::KIND_OVF :
                  is_ld ? mie_pkg::KIND_READ : st_op ? mie_pkg::KIND_WRITE :
                  mie_pkg::KIND_RETIRED;

  // load data alignment; ra holds old destination value
  logic [31:0] old_d;
  assign old_d = (ldest == 5'd0) ? 32'd0 : ra;
  assign ld_sh = ldata >> {~loff, 3'b000};
  always_comb begin
    case (lkind)
      mie_pkg::LK_LB:  ld_v = {{24{ld_sh[7]}}, ld_sh[7:0]};
      mie_pkg::LK_LBU: ld_v = {24'd0, ld_sh[7:0]};
      mie_pkg::LK_LH:  ld_v = loff[1] ? {{16{ldata[15]}}, ldata[15:0]}
                                       : {{16{ldata[31]}}, ldata[31:16]};
      mie_pkg::LK_LHU: ld_v = loff[1] ? {16'd0, ldata[15:0]} : {16'd0, ldata[31:16]};
      mie_pkg::LK_LWL: ld_v = (ldata << {loff, 3'b000})
                              | (old_d & (32'h00FF_FFFF >> {~loff, 3'b000}));
      mie_pkg::LK_LWR: ld_v = ld_sh | (old_d & (32'hFFFF_FF00 << {loff, 3'b000}));
      default:         ld_v = ldata;
    endcase
  end

  // whether execute phase produces a result
  assign halt_now = ~stopped & ~mode & ~lpend & (pc == 32'd0);
  assign exec_go = stopped | (mode ? lpend : ~lpend);

  // divider start
  always_comb begin
    dreq.start = (st == mie_pkg::ST_EXEC) & is_div & ~stopped & ~mode & ~lpend
                 & ~halt_now;
    dreq.sgn = ~fn[0];
    dreq.a = a;
    dreq.b = b;
  end
  mie_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic do_exec;
  assign do_exec = (st == mie_pkg::ST_EXEC) & ~stopped & ~mode & ~lpend & ~halt_now;

  // register file write port
  always_comb begin
    we = 1'b0; wa = wreg; wd = ex_v;
    if (st == mie_pkg::ST_EXEC && !stopped && mode && lpend) begin
      we = (ldest != 5'd0); wa = ldest; wd = ld_v;
    end else if (do_exec && !ovf && !rsvd) begin
      we = wen & (wreg != 5'd0);
    end
  end

  // architectural state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= EntryReset; pc <= EntryReset; hi <= '0; lo <= '0;
      dpend <= 1'b0; dtgt <= '0; lpend <= 1'b0; lkind <= '0; ldest <= '0;
      loff <= '0; stopped <= 1'b0;
    end else begin
      if (cfg_wr) begin
        entry <= pwdata;
        pc <= pwdata;
      end
      if (st == mie_pkg::ST_EXEC) begin
        if (stopped || halt_now) stopped <= 1'b1;
        else if (mode && lpend) lpend <= 1'b0;
        else if (do_exec) begin
          if (ovf || rsvd) stopped <= 1'b1;
          else begin
            if (wr_hi && (ismul || fn == 6'h11)) hi <= hi_v;
            if (wr_lo && (ismul || fn == 6'h13)) lo <= lo_v;
            pc <= dpend ? dtgt : cur + 32'd4;
            dpend <= nb;
            dtgt <= nb ? ntgt : 32'd0;
            if (is_ld) begin
              lpend <= 1'b1; ldest <= rt; loff <= off; lkind <= lk_c;
            end
          end
        end
      end
      if (drsp.done) begin
        hi <= drsp.rem;
        lo <= drsp.quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st == mie_pkg::ST_EXEC) begin
      o_addr <= '0; o_wd <= '0; o_be <= '0; o_exit <= '0;
      if (stopped || halt_now) begin
        o_kind <= mie_pkg::KIND_HALT; o_pc <= pc; o_exit <= rb[7:0];
      end else if (mode) begin
        o_kind <= mie_pkg::KIND_RETIRED; o_pc <= pc;
      end else begin
        o_kind <= kind_c;
        o_pc <= (ovf | rsvd) ? cur : (dpend ? dtgt : cur + 32'd4);
        if (is_ld && !rsvd) o_addr <= {ea[31:2], 2'b00};
        if (st_op) begin
          o_addr <= {ea[31:2], 2'b00}; o_wd <= st_wd; o_be <= st_be;
        end
      end
    end
  end

  // checks
  `MIE_ASSERT_IMP(a_out_kind, m_axis_tvalid, o_kind <= mie_pkg::KIND_HALT,
    "result kind out of range")
  `MIE_ASSERT_IMP(a_no_accept_clear, clr_busy, !s_axis_tready,
    "item accepted during register clear")
  `MIE_ASSERT_NEXT(a_div_done, drsp.done, st == mie_pkg::ST_OUT,
    "divider finished outside divide state")
  `MIE_ASSERT_IMP(a_halt_exit, m_axis_tvalid && o_kind != mie_pkg::KIND_HALT,
    o_exit == 8'd0, "exit value set on non-halt result")
endmodule
`default_nettype wire
